>>> hw/rtl/mt_pkg.sv
package mt_pkg;

  localparam int WORD_W       = 32;
  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;

  localparam logic [WORD_W-1:0] TWIST_VECTOR = 32'h9908b0df;
  localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h80000000;
  localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fffffff;
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_SEED,
    ST_DRAW
  } mt_state_t;

  typedef struct packed {
    logic seeding;
    logic seed_first;
  } mt_feed_ctrl_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y);
    logic [WORD_W-1:0] t;
    t = y ^ (y >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

endpackage

>>> hw/rtl/mt_if.sv
interface mt_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface mt_word_if;
  logic                      valid;
  logic                      ready;
  logic [mt_pkg::WORD_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

>>> hw/rtl/mt19937_word_generator.sv
// mt19937_word_generator: 32-bit mersenne twister word source
//
// in_ch carries requests (restart bit), out_ch carries tempered 32-bit words,
// one word for every request. cfg_we/cfg_wdata write the seed register
// (reset value 5489); it is used only when the state is rebuilt.
//
// the state lives in a row of 624 word cells that shift by one toward the
// head each time a word is made; the new tail word is the twist of the head,
// its neighbor and the cell 397 places down, so one twist step per word.
// a request without restart on a seeded block loads its word into the output
// register on acceptance, so it is shown in the next cycle, and a new request
// can be taken every cycle while the output is not stalled. a request with
// restart, or the first request after reset, first refills the row from the
// seed in the seed state (one multiply per cycle), then draws once the output
// register is free; in_ch.ready stays low meanwhile.
// reset clears the control state; the row holds no valid data until seeded.
// the word sits in an output register; while out_ch.ready is low it holds,
// and a new request is taken only once that register can accept data.
module mt19937_word_generator #(
  parameter int STATE_WORDS  = mt_pkg::STATE_WORDS,
  parameter int TWIST_OFFSET = mt_pkg::TWIST_OFFSET
) (
  input  logic                      clk,
  input  logic                      rst_n,
  mt_req_if.sink                    in_ch,
  mt_word_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [mt_pkg::WORD_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(STATE_WORDS);

  mt_pkg::mt_state_t         state_r;
  mt_pkg::mt_state_t         state_nxt;
  logic [IDX_W-1:0]          cnt_r;
  logic [IDX_W-1:0]          cnt_nxt;
  logic                      seeded_r;
  logic                      seeded_nxt;
  logic [mt_pkg::WORD_W-1:0] seed_r;

  logic                      out_free;
  logic                      accept;
  logic                      need_seed;
  logic                      shift_en;
  logic                      load;
  logic                      seed_done;
  mt_pkg::mt_feed_ctrl_t     feed_ctrl;
  logic [mt_pkg::WORD_W-1:0] feed_word;
  logic [mt_pkg::WORD_W-1:0] words [STATE_WORDS];

  assign accept    = in_ch.valid && in_ch.ready;
  assign need_seed = in_ch.restart || !seeded_r;
  assign seed_done = (cnt_r == IDX_W'(STATE_WORDS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mt_pkg::ST_RUN: begin
        if (accept && need_seed) begin
          state_nxt = mt_pkg::ST_SEED;
        end
      end
      mt_pkg::ST_SEED: begin
        if (seed_done) begin
          state_nxt = mt_pkg::ST_DRAW;
        end
      end
      mt_pkg::ST_DRAW: begin
        if (out_free) begin
          state_nxt = mt_pkg::ST_RUN;
        end
      end
      default: state_nxt = mt_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    in_ch.ready          = 1'b0;
    shift_en             = 1'b0;
    load                 = 1'b0;
    feed_ctrl.seeding    = 1'b0;
    feed_ctrl.seed_first = (cnt_r == '0);
    cnt_nxt              = cnt_r;
    seeded_nxt           = seeded_r;
    case (state_r)
      mt_pkg::ST_RUN: begin
        in_ch.ready = out_free;
        if (in_ch.valid && out_free && !need_seed) begin
          shift_en = 1'b1;
          load     = 1'b1;
        end
        cnt_nxt = '0;
      end
      mt_pkg::ST_SEED: begin
        feed_ctrl.seeding = 1'b1;
        shift_en          = 1'b1;
        cnt_nxt           = cnt_r + 1'b1;
        if (seed_done) begin
          seeded_nxt = 1'b1;
          cnt_nxt    = '0;
        end
      end
      mt_pkg::ST_DRAW: begin
        shift_en = out_free;
        load     = out_free;
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mt_pkg::ST_RUN;
      cnt_r    <= '0;
      seeded_r <= 1'b0;
      seed_r   <= mt_pkg::DEFAULT_SEED;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      seeded_r <= seeded_nxt;
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
    end
  end

  mt_feed #(
    .IDX_W (IDX_W)
  ) u_feed (
    .ctrl      (feed_ctrl),
    .seed      (seed_r),
    .idx       (cnt_r),
    .tail      (words[STATE_WORDS-1]),
    .head      (words[0]),
    .head_next (words[1]),
    .far       (words[TWIST_OFFSET]),
    .word      (feed_word)
  );

  // row of state cells, head at index 0
  for (genvar k = 0; k < STATE_WORDS; k++) begin : g_cell
    if (k == STATE_WORDS - 1) begin : g_tail
      mt_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d        (feed_word),
        .q        (words[k])
      );
    end else begin : g_body
      mt_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d        (words[k+1]),
        .q        (words[k])
      );
    end
  end

  mt_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load),
    .word   (feed_word),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

>>> hw/rtl/mt_cell.sv
module mt_cell (
  input  logic                      clk,
  input  logic                      shift_en,
  input  logic [mt_pkg::WORD_W-1:0] d,
  output logic [mt_pkg::WORD_W-1:0] q
);

  logic [mt_pkg::WORD_W-1:0] word_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      word_r <= d;
    end
  end

  assign q = word_r;

endmodule

>>> hw/rtl/mt_feed.sv
module mt_feed #(
  parameter int IDX_W = 10
) (
  input  mt_pkg::mt_feed_ctrl_t     ctrl,
  input  logic [mt_pkg::WORD_W-1:0] seed,
  input  logic [IDX_W-1:0]          idx,
  input  logic [mt_pkg::WORD_W-1:0] tail,
  input  logic [mt_pkg::WORD_W-1:0] head,
  input  logic [mt_pkg::WORD_W-1:0] head_next,
  input  logic [mt_pkg::WORD_W-1:0] far,
  output logic [mt_pkg::WORD_W-1:0] word
);

  logic [mt_pkg::WORD_W-1:0] mix;
  logic [mt_pkg::WORD_W-1:0] prod;
  logic [mt_pkg::WORD_W-1:0] recur;
  logic [mt_pkg::WORD_W-1:0] y;
  logic [mt_pkg::WORD_W-1:0] twisted;

  always_comb begin
    // knuth recurrence on the newest word
    mix   = tail ^ (tail >> 30);
    prod  = mix * mt_pkg::SEED_MULT;
    recur = prod + {{(mt_pkg::WORD_W-IDX_W){1'b0}}, idx};

    y       = (head & mt_pkg::HIGH_BIT) | (head_next & mt_pkg::LOW_BITS);
    twisted = far ^ (y >> 1);
    if (y[0]) begin
      twisted = twisted ^ mt_pkg::TWIST_VECTOR;
    end

    if (ctrl.seeding) begin
      word = ctrl.seed_first ? seed : recur;
    end else begin
      word = twisted;
    end
  end

endmodule

>>> hw/rtl/mt_out_stage.sv
module mt_out_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  logic [mt_pkg::WORD_W-1:0] word,
  output logic                      free,
  mt_word_if.source                 out_ch
);

  logic                      valid_r;
  logic                      valid_nxt;
  logic [mt_pkg::WORD_W-1:0] value_r;

  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= mt_pkg::temper(word);
    end
  end

  assign out_ch.valid = valid_r;
  assign out_ch.value = value_r;

endmodule

>>> hw/rtl/mt_checker.sv
module mt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_restart,
  input logic out_valid,
  input logic out_ready
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // a stalled word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // a new request is taken only when the output register can accept
  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!out_valid || out_ready))
    else $error("request taken with output register full");

  // reseeding blocks further requests
  a_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_restart |=> !in_ready)
    else $error("request taken during reseed");

  // reseeding gives no word on the next cycle
  a_restart_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_restart |=> !out_valid)
    else $error("word shown before reseed finished");

endmodule

bind mt19937_word_generator mt_checker u_mt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_restart (in_ch.restart),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready)
);

>>> tb/mt_stream_check.sv
`timescale 1ns / 1ps

module mt_stream_check
  import mt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  mt_req_if                 req_ch,
  mt_word_if                word_ch,
  input  logic              cfg_we,
  input  logic [WORD_W-1:0] cfg_wdata,
  output int                errors,
  output int                pending
);

  localparam int UNSEEDED = STATE_WORDS + 1;

  logic [WORD_W-1:0] mt_row [STATE_WORDS];
  int unsigned       row_pos;
  logic [WORD_W-1:0] seed_word;
  logic [WORD_W-1:0] words_due [$];
  int                mismatch_cnt = 0;

  function automatic void fill_row(input logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] prev;
    mt_row[0] = s;
    for (int i = 1; i < STATE_WORDS; i++) begin
      prev = mt_row[i-1];
      mt_row[i] = SEED_MULT * (prev ^ (prev >> 30)) + WORD_W'(i);
    end
    row_pos = STATE_WORDS;
  endfunction

  function automatic void twist_row();
    int                nxt;
    int                far;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] v;
    for (int k = 0; k < STATE_WORDS; k++) begin
      nxt = (k + 1) % STATE_WORDS;
      far = (k + TWIST_OFFSET) % STATE_WORDS;
      y = (mt_row[k] & HIGH_BIT) | (mt_row[nxt] & LOW_BITS);
      v = mt_row[far] ^ (y >> 1);
      if (y[0]) begin
        v = v ^ TWIST_VECTOR;
      end
      mt_row[k] = v;
    end
    row_pos = 0;
  endfunction

  function automatic logic [WORD_W-1:0] shape_word(input logic [WORD_W-1:0] raw);
    logic [WORD_W-1:0] w;
    w = raw;
    w = w ^ (w >> 11);
    w = w ^ ((w << 7) & TEMPER_B);
    w = w ^ ((w << 15) & TEMPER_C);
    w = w ^ (w >> 18);
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] draw_word(input logic restart);
    logic [WORD_W-1:0] raw;
    if (restart || row_pos == UNSEEDED) begin
      fill_row(seed_word);
    end
    if (row_pos >= STATE_WORDS) begin
      twist_row();
    end
    raw = mt_row[row_pos];
    row_pos++;
    return shape_word(raw);
  endfunction

  always @(posedge clk) begin
    logic [WORD_W-1:0] want;
    if (!rst_n) begin
      row_pos = UNSEEDED;
      seed_word = DEFAULT_SEED;
      words_due.delete();
    end else begin
      if (cfg_we) begin
        seed_word = cfg_wdata;
      end
      if (req_ch.valid && req_ch.ready) begin
        words_due.push_back(draw_word(req_ch.restart));
      end
      if (word_ch.valid && word_ch.ready) begin
        if (words_due.size() == 0) begin
          $error("value: expected no word, actual %h", word_ch.value);
          mismatch_cnt++;
        end else begin
          want = words_due.pop_front();
          if (word_ch.value !== want) begin
            $error("value: expected %h, actual %h", want, word_ch.value);
            mismatch_cnt++;
          end
        end
      end
    end
    errors <= mismatch_cnt;
    pending <= words_due.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import mt_pkg::*;

  localparam int RANDOM_REQS = 1950;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [WORD_W-1:0] cfg_wdata;
  int                errors;
  int                pending;
  bit                hold_now = 1'b0;
  bit                hold_done = 1'b0;
  int                tx_calm = 0;

  mt_req_if  req_ch ();
  mt_word_if word_ch ();

  always #10 clk = ~clk;

  mt19937_word_generator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (word_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  mt_stream_check word_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ch    (req_ch),
    .word_ch   (word_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic send_req(input logic rs);
    int gap;
    req_ch.valid <= 1'b1;
    req_ch.restart <= rs;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 15) == 0) begin
        tx_calm = $urandom_range(30, 80);
      end
      gap = pick_gap();
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_seed(input logic [WORD_W-1:0] s);
    cfg_we <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // result side
  initial begin
    int n;
    word_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_now && !hold_done) begin
        // long hold-off so the block backs up into the request side
        word_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_done = 1'b1;
      end
      word_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(50, 150)) @(posedge clk);
      end
      n = pick_gap();
      if (n > 0) begin
        word_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    int                sent;
    int                phase;
    int                plen;
    logic              rs;
    logic [WORD_W-1:0] s;

    rst_n <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.restart <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first request after reset seeds from the default seed
    send_req(1'b0);
    send_req(1'b0);
    send_req(1'b0);
    // restart mid-stream
    send_req(1'b1);
    send_req(1'b0);
    send_req(1'b0);

    // new seed has no effect until a restart
    wait_idle();
    write_seed('0);
    send_req(1'b0);
    send_req(1'b0);
    send_req(1'b1);
    send_req(1'b0);

    wait_idle();
    write_seed('1);
    send_req(1'b1);
    send_req(1'b0);
    send_req(1'b0);

    wait_idle();
    write_seed(HIGH_BIT);
    send_req(1'b1);
    send_req(1'b1);
    send_req(1'b0);

    wait_idle();
    write_seed(DEFAULT_SEED);
    send_req(1'b1);
    send_req(1'b0);

    sent = 0;
    phase = 0;
    while (sent < RANDOM_REQS) begin
      plen = (phase == 0) ? 700 : $urandom_range(150, 900);
      if (plen > RANDOM_REQS - sent) begin
        plen = RANDOM_REQS - sent;
      end
      wait_idle();
      case ($urandom_range(0, 5))
        0: s = '0;
        1: s = '1;
        default: s = $urandom();
      endcase
      write_seed(s);
      for (int i = 0; i < plen; i++) begin
        if (phase == 0 && i == 200) begin
          hold_now = 1'b1;
        end
        if (phase == 1 && i == plen / 2) begin
          wait_idle();
        end
        if (i == 0) begin
          rs = (phase == 0) || ($urandom_range(0, 1) == 1);
        end else begin
          rs = (phase != 0) && ($urandom_range(0, 249) == 0);
        end
        send_req(rs);
      end
      sent += plen;
      phase++;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[mt19937_word_generator] OK");
    end else begin
      $display("[mt19937_word_generator] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[mt19937_word_generator] ERROR");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/mt_pkg.sv
hw/rtl/mt_if.sv
hw/rtl/mt_cell.sv
hw/rtl/mt_feed.sv
hw/rtl/mt_out_stage.sv
hw/rtl/mt19937_word_generator.sv
hw/rtl/mt_checker.sv
tb/mt_stream_check.sv
tb/tb.sv
